// ----- sv/calendar_to_epoch_seconds_unit_macros.svh -----
// Assertion macros for the calendar to epoch seconds unit.
// Used by the top level only; no other dependencies.
`ifndef CALENDAR_TO_EPOCH_SECONDS_UNIT_MACROS_SVH
`define CALENDAR_TO_EPOCH_SECONDS_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define C2E_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("c2e assertion failed");

// Next-cycle implication, disabled during reset
`define C2E_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("c2e assertion failed");

`endif

// ----- sv/c2e_pkg.sv -----
// Shared types, constants and the month table for the epoch seconds unit.
// No dependencies.
package c2e_pkg;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int NANOS_W = 30;
  localparam int SECS_W  = 37;

  // Internal widths
  localparam int DAYS_W = 21;  // signed day count since epoch
  localparam int TOD_W  = 17;  // seconds within the day, unchecked fields
  localparam int YDAY_W = 10;  // signed day of year, day zero gives -1

  localparam int EPOCH_YEAR         = 1970;
  localparam int DAYS_PER_YEAR      = 365;
  localparam int LEAPS_BEFORE_EPOCH = 478;
  localparam int EPOCH_DAYS         = EPOCH_YEAR * DAYS_PER_YEAR + LEAPS_BEFORE_EPOCH;

  // x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for x below 8192
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;

  // 86400 = 675 << 7
  localparam int DAY_SECS_ODD   = 675;
  localparam int DAY_SECS_SHIFT = 7;

  typedef struct packed {
    logic [YEAR_W-1:0]  year_in;
    logic [MONTH_W-1:0] month_in;
    logic [MDAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0]  hour_in;
    logic [MIN_W-1:0]   minute_in;
    logic [SEC_W-1:0]   second_in;
    logic [NANOS_W-1:0] nanos_in;
  } c2e_in_t;

  typedef struct packed {
    logic signed [SECS_W-1:0] epoch_seconds;
    logic [NANOS_W-1:0]       nanos_out;
  } c2e_out_t;

  // Days before the month, February as 28 days; months past December clamp
  function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    unique case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    return d;
  endfunction

endpackage

// ----- sv/c2e_day_count.sv -----
// Two-stage day count since epoch from year, month and day of month.
// Depends on c2e_pkg.
module c2e_day_count import c2e_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [YEAR_W-1:0]        year_i,
  input  logic [MONTH_W-1:0]       month_i,
  input  logic [MDAY_W-1:0]        mday_i,
  output logic signed [DAYS_W-1:0] days_o
);

  localparam int ACC_W = DAYS_W + 2;

  // ---------------- stage 1: divisions by constants, year days, month offset
  logic [YEAR_W:0]   yp3, yp99, yp399;
  logic [10:0]       x4;
  logic [25:0]       c100_prod;
  logic [23:0]       c400_prod;
  logic [24:0]       q100_prod;
  logic [10:0]       ceil4_d, ceil4_q;
  logic [6:0]        c100_d, c100_q;
  logic [4:0]        c400_d, c400_q;
  logic [5:0]        q100_d, q100_q;
  logic [DAYS_W-1:0] ydays_d, ydays_q;
  logic signed [YDAY_W-1:0] ydp_d, ydp_q;
  logic              late_d, late_q;
  logic [YEAR_W-1:0] year_q;

  always_comb begin
    yp3       = {1'b0, year_i} + (YEAR_W+1)'(3);
    yp99      = {1'b0, year_i} + (YEAR_W+1)'(99);
    yp399     = {1'b0, year_i} + (YEAR_W+1)'(399);
    x4        = yp399[YEAR_W:2];
    ceil4_d   = yp3[YEAR_W:2];
    c100_prod = 26'(yp99) * 26'(DIV100_MUL);
    c100_d    = c100_prod[25:DIV100_SHIFT];
    c400_prod = 24'(x4) * 24'(DIV100_MUL);
    c400_d    = c400_prod[23:DIV100_SHIFT];
    q100_prod = 25'(year_i) * 25'(DIV100_MUL);
    q100_d    = q100_prod[24:DIV100_SHIFT];
    ydays_d   = DAYS_W'(year_i) * DAYS_W'(DAYS_PER_YEAR);
    ydp_d     = $signed(YDAY_W'(days_before_month(month_i)) + YDAY_W'(mday_i)
                - YDAY_W'(1));
    late_d    = (month_i > MONTH_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      year_q  <= year_i;
      ceil4_q <= ceil4_d;
      c100_q  <= c100_d;
      c400_q  <= c400_d;
      q100_q  <= q100_d;
      ydays_q <= ydays_d;
      ydp_q   <= ydp_d;
      late_q  <= late_d;
    end
  end

  // ---------------- stage 2: leap test, leap count, final sum
  logic              cent;
  logic              leap;
  logic [10:0]       leaps;
  logic [ACC_W-1:0]  days_acc;
  logic signed [DAYS_W-1:0] days_d, days_q;

  always_comb begin
    cent  = (13'(year_q) == 13'(q100_q) * 13'(100));
    leap  = (year_q[1:0] == 2'b00) && (!cent || (q100_q[1:0] == 2'b00));
    leaps = ceil4_q - 11'(c100_q) + 11'(c400_q);
    days_acc = ACC_W'(ydays_q) + ACC_W'(leaps) + ACC_W'(ydp_q)
             + ACC_W'(leap && late_q) - ACC_W'(EPOCH_DAYS);
    days_d = $signed(days_acc[DAYS_W-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days_q <= days_d;
    end
  end

  assign days_o = days_q;

endmodule

// ----- sv/calendar_to_epoch_seconds_unit.sv -----
// Top level: Gregorian date and time to signed seconds since the epoch.
// Depends on c2e_pkg, c2e_day_count and calendar_to_epoch_seconds_unit_macros.svh.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | input     | in_valid_i / in_stall_o | c2e_in_t  (date, time, ns)
//  out     | output    | out_valid_o/out_stall_i | c2e_out_t (seconds, ns)
//
// One item per cycle unless a stalled result holds the pipe.
// Four register stages: constant divides, leap count and day sum, day-to-
// seconds multiply, then time-of-day add into the output register.
// A stalled result freezes the whole pipe; the input stalls only then.
// Reset clears the stage valid bits; payload registers are not reset.
`include "calendar_to_epoch_seconds_unit_macros.svh"

module calendar_to_epoch_seconds_unit import c2e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  c2e_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output c2e_out_t out_data_o
);

  localparam logic signed [SECS_W-1:0] SECS_MIN = -37'sd63000000000;
  localparam logic signed [SECS_W-1:0] SECS_MAX = 37'sd68000000000;

  logic pipe_en;
  logic v1_q, v2_q, v3_q, out_valid_q;

  // Whole pipe advances unless a result is held
  assign pipe_en    = !(out_valid_q && out_stall_i);
  assign in_stall_o = !pipe_en;

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Day count, stages 1 and 2
  logic signed [DAYS_W-1:0] days;

  c2e_day_count u_day_count (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .year_i  (in_data_i.year_in),
    .month_i (in_data_i.month_in),
    .mday_i  (in_data_i.day_of_month),
    .days_o  (days)
  );

  // Seconds within the day, stage 1, then carried along
  logic [TOD_W-1:0]   tod_d, tod1_q, tod2_q, tod3_q;
  logic [NANOS_W-1:0] ns1_q, ns2_q, ns3_q;

  assign tod_d = TOD_W'(in_data_i.hour_in) * TOD_W'(3600)
               + TOD_W'(in_data_i.minute_in) * TOD_W'(60)
               + TOD_W'(in_data_i.second_in);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      tod1_q <= tod_d;
      tod2_q <= tod1_q;
      tod3_q <= tod2_q;
      ns1_q  <= in_data_i.nanos_in;
      ns2_q  <= ns1_q;
      ns3_q  <= ns2_q;
    end
  end

  // Stage 3: days times the odd factor of 86400
  logic signed [31:0] prod_d, prod_q;

  assign prod_d = $signed(32'(days)) * $signed(32'(DAY_SECS_ODD));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_q <= prod_d;
    end
  end

  // Stage 4: shift in the power of two, add time of day
  c2e_out_t out_d, out_q;

  always_comb begin
    out_d.epoch_seconds = $signed({prod_q[SECS_W-DAY_SECS_SHIFT-1:0],
                                   {DAY_SECS_SHIFT{1'b0}}})
                        + $signed(SECS_W'(tod3_q));
    out_d.nanos_out     = ns3_q;
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  logic secs_in_range;

  assign secs_in_range = (out_q.epoch_seconds >= SECS_MIN) &&
                         (out_q.epoch_seconds <= SECS_MAX);

  `C2E_ASSERT_IMP(a_secs_range, clk_i, rst_ni, out_valid_q, secs_in_range)
  `C2E_ASSERT_NXT(a_hold_valids, clk_i, rst_ni, !pipe_en, $stable({v1_q, v2_q, v3_q, out_valid_q}))
  `C2E_ASSERT_NXT(a_last_stage_moves, clk_i, rst_ni, pipe_en && v3_q, out_valid_q)

endmodule

// ----- dv/c2e_result_check.sv -----
`timescale 1ns / 100ps
// Result checker for the calendar to epoch seconds unit: predicts each result
// from the accepted input transfer and compares it with the output transfers.
// Depends on c2e_pkg for the channel payload types.
module c2e_result_check import c2e_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  c2e_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  c2e_out_t out_data_i,
  output int       fail_count_o,
  output int       pending_o
);

  localparam longint UNIX_YEAR     = 1970;
  localparam longint YEAR_DAYS     = 365;
  localparam longint DAY_SECONDS   = 86400;
  localparam int     REPORT_LIMIT  = 10;
  localparam int     LAST_MONTH    = 11;
  localparam int     FEBRUARY      = 1;

  // Cumulative days before each month, February as 28
  int cum_days [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  c2e_out_t expected_times_q [$];
  int       mismatch_count = 0;

  function automatic bit gregorian_leap(longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Leap years in [0, y-1]
  function automatic longint leap_days_before(longint y);
    return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic c2e_out_t epoch_of(c2e_in_t d);
    c2e_out_t r;
    longint   yr;
    int       mo;
    longint   yday;
    longint   days;
    longint   secs;
    yr = longint'(d.year_in);
    mo = (int'(d.month_in) > LAST_MONTH) ? LAST_MONTH : int'(d.month_in);
    yday = longint'(d.day_of_month) - 1 + cum_days[mo];
    if (gregorian_leap(yr) && mo > FEBRUARY) yday += 1;
    days = (yr - UNIX_YEAR) * YEAR_DAYS + leap_days_before(yr)
         - leap_days_before(UNIX_YEAR) + yday;
    secs = days * DAY_SECONDS + longint'(d.hour_in) * 3600
         + longint'(d.minute_in) * 60 + longint'(d.second_in);
    r.epoch_seconds = secs[SECS_W-1:0];
    r.nanos_out     = d.nanos_in;
    return r;
  endfunction

  // Compare output transfers against the oldest prediction, then queue new ones
  always @(posedge clk_i) begin
    c2e_out_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_times_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: unexpected result secs=%0d ns=%0d", $realtime,
                     out_data_i.epoch_seconds, out_data_i.nanos_out);
        end else begin
          want = expected_times_q.pop_front();
          if (out_data_i.epoch_seconds !== want.epoch_seconds ||
              out_data_i.nanos_out !== want.nanos_out) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: mismatch secs exp=%0d got=%0d, ns exp=%0d got=%0d",
                       $realtime, want.epoch_seconds, out_data_i.epoch_seconds,
                       want.nanos_out, out_data_i.nanos_out);
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_times_q.push_back(epoch_of(in_data_i));
      fail_count_o <= mismatch_count;
      pending_o    <= expected_times_q.size();
    end
  end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for calendar_to_epoch_seconds_unit: clock, reset, directed and
// random date transfers, random output stalls. Depends on c2e_pkg, c2e_result_check.
module tb import c2e_pkg::*;;

  localparam int RANDOM_ITEMS = 1600;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 300;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  c2e_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  c2e_out_t out_data_o;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int burst_left = 0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  calendar_to_epoch_seconds_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  c2e_result_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic c2e_in_t mk_date(int y, int m, int d, int h, int mi, int s, int ns);
    c2e_in_t r;
    r.year_in      = y[YEAR_W-1:0];
    r.month_in     = m[MONTH_W-1:0];
    r.day_of_month = d[MDAY_W-1:0];
    r.hour_in      = h[HOUR_W-1:0];
    r.minute_in    = mi[MIN_W-1:0];
    r.second_in    = s[SEC_W-1:0];
    r.nanos_in     = ns[NANOS_W-1:0];
    return r;
  endfunction

  // Mostly real calendar dates; the rest raw bit patterns
  function automatic c2e_in_t random_date();
    c2e_in_t r;
    int mo;
    int mdays_max [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if ($urandom_range(0, 3) == 0) begin
      r.year_in      = YEAR_W'($urandom);
      r.month_in     = MONTH_W'($urandom);
      r.day_of_month = MDAY_W'($urandom);
      r.hour_in      = HOUR_W'($urandom);
      r.minute_in    = MIN_W'($urandom);
      r.second_in    = SEC_W'($urandom);
      r.nanos_in     = NANOS_W'($urandom);
    end else begin
      mo = $urandom_range(0, 11);
      r.year_in      = ($urandom_range(0, 1) == 0) ? YEAR_W'($urandom_range(1900, 2100))
                                                   : YEAR_W'($urandom_range(1, 4095));
      r.month_in     = MONTH_W'(mo);
      r.day_of_month = MDAY_W'($urandom_range(1, mdays_max[mo]));
      r.hour_in      = HOUR_W'($urandom_range(0, 23));
      r.minute_in    = MIN_W'($urandom_range(0, 59));
      r.second_in    = SEC_W'($urandom_range(0, 59));
      r.nanos_in     = NANOS_W'($urandom_range(0, 999999999));
    end
    return r;
  endfunction

  // Sender gap: bursts with none, mostly short, a few long
  function automatic int sender_gap();
    int pick;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one transfer at the falling edge and hold it until accepted
  task automatic send_date(c2e_in_t d);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Receiver stalls, with one long hold-off while the sender keeps offering
  initial begin
    int run;
    int n;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      out_stall_i <= 1'b0;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 20);
      repeat (run) @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        n = HOLD_CYCLES;
      end else if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(15, 60);
      end else begin
        n = $urandom_range(1, 3);
      end
      out_stall_i <= 1'b1;
      repeat (n) @(negedge clk_i);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus and verdict
  initial begin
    c2e_in_t directed_q [$];
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    directed_q.push_back(mk_date(1970, 0, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_date(1969, 11, 31, 23, 59, 59, 999999999));
    directed_q.push_back(mk_date(0, 0, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_date(0, 0, 1, 0, 0, 0, 1));
    directed_q.push_back(mk_date(0, 2, 1, 12, 0, 0, 0));
    directed_q.push_back(mk_date(1, 0, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_date(4095, 11, 31, 23, 59, 59, 999999999));
    directed_q.push_back(mk_date(4095, 15, 31, 31, 63, 63, 32'h3FFF_FFFF));
    directed_q.push_back(mk_date(2023, 12, 5, 1, 2, 3, 4));
    directed_q.push_back(mk_date(2024, 13, 15, 0, 0, 0, 0));
    directed_q.push_back(mk_date(2000, 14, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_date(1999, 1, 31, 0, 0, 0, 0));
    directed_q.push_back(mk_date(2000, 2, 0, 0, 0, 0, 0));
    directed_q.push_back(mk_date(2000, 1, 29, 0, 0, 0, 0));
    directed_q.push_back(mk_date(2000, 2, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_date(1900, 2, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_date(2100, 2, 1, 0, 0, 0, 0));
    directed_q.push_back(mk_date(2024, 11, 31, 23, 59, 59, 0));
    directed_q.push_back(mk_date(2038, 0, 19, 3, 14, 8, 0));
    directed_q.push_back(mk_date(1970, 0, 1, 31, 63, 63, 1000000000));
    directed_q.push_back(mk_date(2730, 5, 15, 17, 42, 5, 123456789));
    foreach (directed_q[i]) send_date(directed_q[i]);

    hold_req = 1'b1;
    repeat (RANDOM_ITEMS) send_date(random_date());
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+sv
sv/c2e_pkg.sv
sv/c2e_day_count.sv
sv/calendar_to_epoch_seconds_unit.sv
dv/c2e_result_check.sv
dv/tb.sv
